>>> design/i2cra_pkg.sv
package i2cra_pkg;

    localparam int PHASE_W = 10;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 10'd4;

    localparam int CMD_W = 2;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

>>> design/i2cra_core.sv
module i2cra_core
    import i2cra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [PHASE_W-1:0] i_phase_ticks,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [6:0]         i_slave_addr,
    input  logic [7:0]         i_reg_addr,
    input  logic [7:0]         i_write_data,
    input  logic               i_sda_in,
    output t_result            o_result
);

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NACK_ADDRW = 2'd1;
    localparam logic [1:0] STATUS_NACK_REG   = 2'd2;
    localparam logic [1:0] STATUS_NACK_ADDRR = 2'd3;

    localparam logic [3:0] BIT_ACK = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ADDRW,
        ST_REG,
        ST_DATA,
        ST_RESTART,
        ST_ADDRR,
        ST_READ,
        ST_STOP
    } t_phase;

    t_phase             r_state, n_state;
    logic [1:0]         r_quarter, n_quarter;
    logic [3:0]         r_bit_count, n_bit_count;
    logic [7:0]         r_shift, n_shift;
    logic [PHASE_W-1:0] r_tick, n_tick;
    logic [6:0]         r_slave, n_slave;
    logic [7:0]         r_reg, n_reg;
    logic [7:0]         r_data, n_data;
    logic               r_is_read, n_is_read;
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_read, n_read;

    logic [PHASE_W-1:0] limit;
    logic               send_stage;
    logic               scl;
    logic               pull;
    logic               done;

    assign limit = (i_phase_ticks == '0) ? PHASE_W'(1) : i_phase_ticks;

    always_comb begin
        n_state     = r_state;
        n_quarter   = r_quarter;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_slave     = r_slave;
        n_reg       = r_reg;
        n_data      = r_data;
        n_is_read   = r_is_read;
        n_status    = r_status;
        n_read      = r_read;
        scl         = 1'b1;
        pull        = 1'b0;
        done        = 1'b0;

        if (r_state == ST_IDLE && (i_cmd == CMD_WRITE || i_cmd == CMD_READ)) begin
            n_slave     = i_slave_addr;
            n_reg       = i_reg_addr;
            n_data      = i_write_data;
            n_is_read   = (i_cmd == CMD_READ);
            n_status    = STATUS_OK;
            n_state     = ST_START;
            n_quarter   = 2'd0;
            n_tick      = '0;
            n_bit_count = 4'd0;
        end

        send_stage = (n_state == ST_ADDRW) || (n_state == ST_REG) ||
                     (n_state == ST_DATA) || (n_state == ST_ADDRR);

        case (n_state)
            ST_START, ST_RESTART: begin
                scl  = (n_quarter == 2'd1) || (n_quarter == 2'd2) ||
                       (n_quarter == 2'd0 && n_state == ST_START);
                pull = n_quarter[1];
            end
            ST_STOP: begin
                scl  = (n_quarter != 2'd0);
                pull = !n_quarter[1];
            end
            ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR, ST_READ: begin
                scl  = (n_quarter == 2'd1) || (n_quarter == 2'd2);
                pull = send_stage && (n_bit_count < BIT_ACK) && !n_shift[7];
            end
            default: begin
                scl  = 1'b1;
                pull = 1'b0;
            end
        endcase

        if (n_state != ST_IDLE) begin
            if ({1'b0, n_tick} + 11'd1 < {1'b0, limit}) begin
                n_tick = n_tick + PHASE_W'(1);
            end else begin
                n_tick = '0;
                if (n_quarter == 2'd2) begin
                    if (n_state == ST_READ && n_bit_count < BIT_ACK) begin
                        n_shift = {n_shift[6:0], i_sda_in};
                    end else if (send_stage && n_bit_count >= BIT_ACK) begin
                        n_shift = {7'd0, i_sda_in};
                    end
                end
                if (n_quarter == 2'd3) begin
                    n_quarter = 2'd0;
                    case (n_state)
                        ST_START: begin
                            n_state     = ST_ADDRW;
                            n_shift     = {n_slave, 1'b0};
                            n_bit_count = 4'd0;
                        end
                        ST_RESTART: begin
                            n_state     = ST_ADDRR;
                            n_shift     = {n_slave, 1'b1};
                            n_bit_count = 4'd0;
                        end
                        ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR: begin
                            if (n_bit_count < BIT_ACK) begin
                                n_shift     = {n_shift[6:0], 1'b0};
                                n_bit_count = n_bit_count + 4'd1;
                            end else if (n_shift[0]) begin
                                if (n_state == ST_ADDRW) begin
                                    n_status = STATUS_NACK_ADDRW;
                                end else if (n_state == ST_ADDRR) begin
                                    n_status = STATUS_NACK_ADDRR;
                                end else begin
                                    n_status = STATUS_NACK_REG;
                                end
                                n_state = ST_STOP;
                            end else if (n_state == ST_ADDRW) begin
                                n_state     = ST_REG;
                                n_shift     = n_reg;
                                n_bit_count = 4'd0;
                            end else if (n_state == ST_REG) begin
                                n_bit_count = 4'd0;
                                if (n_is_read) begin
                                    n_state = ST_RESTART;
                                end else begin
                                    n_state = ST_DATA;
                                    n_shift = n_data;
                                end
                            end else if (n_state == ST_DATA) begin
                                n_state = ST_STOP;
                            end else begin
                                n_state     = ST_READ;
                                n_shift     = 8'd0;
                                n_bit_count = 4'd0;
                            end
                        end
                        ST_READ: begin
                            if (n_bit_count < BIT_ACK) begin
                                n_bit_count = n_bit_count + 4'd1;
                                if (n_bit_count == BIT_ACK) begin
                                    n_read = n_shift;
                                end
                            end else begin
                                n_state = ST_STOP;
                            end
                        end
                        ST_STOP: begin
                            n_state     = ST_IDLE;
                            n_bit_count = 4'd0;
                            done        = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end else begin
                    n_quarter = n_quarter + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_quarter   <= 2'd0;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_tick      <= '0;
            r_slave     <= 7'd0;
            r_reg       <= 8'd0;
            r_data      <= 8'd0;
            r_is_read   <= 1'b0;
            r_status    <= STATUS_OK;
            r_read      <= 8'd0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_quarter   <= n_quarter;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_tick      <= n_tick;
            r_slave     <= n_slave;
            r_reg       <= n_reg;
            r_data      <= n_data;
            r_is_read   <= n_is_read;
            r_status    <= n_status;
            r_read      <= n_read;
        end
    end

    always_comb begin
        o_result.scl_level    = scl;
        o_result.sda_pull_low = pull;
        o_result.busy_res     = (n_state != ST_IDLE);
        o_result.done_res     = done;
        o_result.status       = n_status;
        o_result.read_data    = n_read;
    end

endmodule

>>> design/i2c_register_access_master.sv
// Channel   Direction  Payload
// s_axis    in         tuser: cmd[1:0]; tdata: slave_addr, reg_addr, write_data, sda_in
// m_axis    out        tdata: scl_level, sda_pull_low, busy_res, done_res, status, read_data
// cfg       in         i_cfg_wr_en, i_cfg_wr_data: phase_ticks
//
// The sequencer state and the output register update at the clock edge that accepts a request,
// and the result appears on m_axis in the cycle after the request is accepted.
// A new request is accepted every cycle while the output register is empty or being taken.
// When m_axis stalls with a result waiting, s_axis_tready drops until it is taken.
// Synchronous active-low reset returns the sequencer to idle and sets phase_ticks to four.
module i2c_register_access_master
    import i2cra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [PHASE_W-1:0]    i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: slave_addr[6:0], reg_addr[14:7], write_data[22:15], sda_in[23].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: scl_level, sda_pull_low, busy_res, done_res, status[5:4],
    // read_data[13:6], zero fill[15:14].
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [PHASE_W-1:0] r_phase_ticks;
    logic               r_out_valid;
    t_result            r_out;
    t_result            step_result;
    logic               accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_phase_ticks <= i_cfg_wr_data;
        end
    end

    i2cra_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_phase_ticks (r_phase_ticks),
        .i_cmd         (s_axis_tuser),
        .i_slave_addr  (s_axis_tdata[6:0]),
        .i_reg_addr    (s_axis_tdata[14:7]),
        .i_write_data  (s_axis_tdata[22:15]),
        .i_sda_in      (s_axis_tdata[23]),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), r_out};

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    a_idle_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.busy_res) |-> (r_out.scl_level && !r_out.sda_pull_low))
        else $error("bus not released while idle");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_out))
        else $error("stalled result changed");

endmodule

>>> verif/i2cra_tb_pkg.sv
package i2cra_tb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NACK_ADDR_WR = 2'd1,
        STAT_NACK_BYTE    = 2'd2,
        STAT_NACK_ADDR_RD = 2'd3
    } t_status;

endpackage

>>> verif/i2cra_bus_checker.sv
module i2cra_bus_checker
    import i2cra_pkg::*;
    import i2cra_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [PHASE_W-1:0]    i_cfg_wr_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_pending,
    output int                    o_mismatches
);

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_ADDR_WR,
        SEQ_REG,
        SEQ_DATA,
        SEQ_RESTART,
        SEQ_ADDR_RD,
        SEQ_READ,
        SEQ_STOP
    } t_seq;

    t_seq               seq;
    logic [1:0]         quarter_idx;
    logic [3:0]         bit_idx;
    logic [7:0]         shifter;
    int                 tick_cnt;
    logic [6:0]         dev_addr;
    logic [7:0]         reg_addr;
    logic [7:0]         wr_byte;
    logic               rd_mode;
    t_status            bus_status;
    logic [7:0]         rd_byte;
    logic [PHASE_W-1:0] quarter_len;
    t_result            levels_q[$];
    t_result            seen_levels;
    t_result            want_levels;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 pending = 0;

    assign o_pending = pending;
    assign o_mismatches = mismatches;

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: result %0d: %s is %0h, %0h expected", $time, results_seen, what, got,
                 want);
        mismatches++;
    endtask

    function automatic logic is_tx_stage(t_seq s);
        return s == SEQ_ADDR_WR || s == SEQ_REG || s == SEQ_DATA || s == SEQ_ADDR_RD;
    endfunction

    function automatic void load_byte(t_seq s, logic [7:0] value);
        seq = s;
        shifter = value;
        bit_idx = 4'd0;
    endfunction

    // Runs at the end of the fourth quarter; returns 1 when the stop condition completes.
    function automatic logic close_segment();
        logic fin;
        fin = 1'b0;
        case (seq)
            SEQ_START: load_byte(SEQ_ADDR_WR, {dev_addr, 1'b0});
            SEQ_RESTART: load_byte(SEQ_ADDR_RD, {dev_addr, 1'b1});
            SEQ_ADDR_WR, SEQ_REG, SEQ_DATA, SEQ_ADDR_RD: begin
                if (bit_idx < 4'd8) begin
                    shifter = shifter << 1;
                    bit_idx = bit_idx + 4'd1;
                end else if (shifter[0]) begin
                    bus_status = (seq == SEQ_ADDR_WR) ? STAT_NACK_ADDR_WR :
                                 (seq == SEQ_ADDR_RD) ? STAT_NACK_ADDR_RD : STAT_NACK_BYTE;
                    seq = SEQ_STOP;
                end else begin
                    case (seq)
                        SEQ_ADDR_WR: load_byte(SEQ_REG, reg_addr);
                        SEQ_REG: begin
                            if (rd_mode) begin
                                seq = SEQ_RESTART;
                                bit_idx = 4'd0;
                            end else begin
                                load_byte(SEQ_DATA, wr_byte);
                            end
                        end
                        SEQ_DATA: seq = SEQ_STOP;
                        default: load_byte(SEQ_READ, 8'h00);
                    endcase
                end
            end
            SEQ_READ: begin
                if (bit_idx < 4'd8) begin
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx == 4'd8) begin
                        rd_byte = shifter;
                    end
                end else begin
                    seq = SEQ_STOP;
                end
            end
            SEQ_STOP: begin
                seq = SEQ_IDLE;
                bit_idx = 4'd0;
                fin = 1'b1;
            end
            default: seq = SEQ_IDLE;
        endcase
        return fin;
    endfunction

    function automatic t_result advance_sequencer(logic [CMD_W-1:0] cmd,
                                                  logic [IN_DATA_W-1:0] payload);
        t_result r;
        int lim;
        logic sda;
        sda = payload[23];
        lim = (quarter_len == '0) ? 1 : int'(quarter_len);
        r = '0;
        if (seq == SEQ_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
            dev_addr = payload[6:0];
            reg_addr = payload[14:7];
            wr_byte = payload[22:15];
            rd_mode = (cmd == CMD_READ);
            bus_status = STAT_OK;
            seq = SEQ_START;
            quarter_idx = 2'd0;
            tick_cnt = 0;
            bit_idx = 4'd0;
        end
        case (seq)
            SEQ_START, SEQ_RESTART: begin
                r.scl_level = quarter_idx == 2'd1 || quarter_idx == 2'd2 ||
                              (quarter_idx == 2'd0 && seq == SEQ_START);
                r.sda_pull_low = quarter_idx >= 2'd2;
            end
            SEQ_STOP: begin
                r.scl_level = quarter_idx != 2'd0;
                r.sda_pull_low = quarter_idx <= 2'd1;
            end
            SEQ_IDLE: begin
                r.scl_level = 1'b1;
                r.sda_pull_low = 1'b0;
            end
            default: begin
                r.scl_level = quarter_idx == 2'd1 || quarter_idx == 2'd2;
                r.sda_pull_low = is_tx_stage(seq) && bit_idx < 4'd8 && !shifter[7];
            end
        endcase
        if (seq != SEQ_IDLE) begin
            if (tick_cnt + 1 < lim) begin
                tick_cnt++;
            end else begin
                tick_cnt = 0;
                if (quarter_idx == 2'd2) begin
                    if (seq == SEQ_READ && bit_idx < 4'd8) begin
                        shifter = {shifter[6:0], sda};
                    end else if (is_tx_stage(seq) && bit_idx >= 4'd8) begin
                        shifter = {7'd0, sda};
                    end
                end
                if (quarter_idx == 2'd3) begin
                    quarter_idx = 2'd0;
                    r.done_res = close_segment();
                end else begin
                    quarter_idx = quarter_idx + 2'd1;
                end
            end
        end
        r.busy_res = seq != SEQ_IDLE;
        r.status = bus_status;
        r.read_data = rd_byte;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq = SEQ_IDLE;
            quarter_idx = 2'd0;
            bit_idx = 4'd0;
            shifter = 8'h00;
            tick_cnt = 0;
            dev_addr = 7'h00;
            reg_addr = 8'h00;
            wr_byte = 8'h00;
            rd_mode = 1'b0;
            bus_status = STAT_OK;
            rd_byte = 8'h00;
            quarter_len = PHASE_TICKS_RESET;
            levels_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                seen_levels = i_m_tdata[RESULT_W-1:0];
                if (levels_q.size() == 0) begin
                    report_mismatch("result with no request", i_m_tdata, 0);
                end else begin
                    want_levels = levels_q.pop_front();
                    if (seen_levels.scl_level != want_levels.scl_level)
                        report_mismatch("scl_level", seen_levels.scl_level,
                                        want_levels.scl_level);
                    if (seen_levels.sda_pull_low != want_levels.sda_pull_low)
                        report_mismatch("sda_pull_low", seen_levels.sda_pull_low,
                                        want_levels.sda_pull_low);
                    if (seen_levels.busy_res != want_levels.busy_res)
                        report_mismatch("busy_res", seen_levels.busy_res, want_levels.busy_res);
                    if (seen_levels.done_res != want_levels.done_res)
                        report_mismatch("done_res", seen_levels.done_res, want_levels.done_res);
                    if (seen_levels.status != want_levels.status)
                        report_mismatch("status", seen_levels.status, want_levels.status);
                    if (seen_levels.read_data != want_levels.read_data)
                        report_mismatch("read_data", seen_levels.read_data,
                                        want_levels.read_data);
                    if (i_m_tdata[OUT_DATA_W-1:RESULT_W] != '0)
                        report_mismatch("zero fill", i_m_tdata[OUT_DATA_W-1:RESULT_W], 0);
                end
            end
            if (i_cfg_wr_en) begin
                quarter_len = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                levels_q.push_back(advance_sequencer(i_s_tuser, i_s_tdata));
            end
        end
        pending <= levels_q.size();
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    import i2cra_pkg::*;
    import i2cra_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 300;
    localparam int RANDOM_PHASES = 3;
    localparam int PHASE_MAX = (1 << PHASE_W) - 1;

    typedef enum int {
        NACK_NONE    = 0,
        NACK_ADDR_WR = 1,
        NACK_REG     = 2,
        NACK_THIRD   = 3
    } t_nack;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [PHASE_W-1:0]    i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    pending;
    int                    mismatches;
    int                    phase_len = int'(PHASE_TICKS_RESET);
    int                    burst_left = 0;
    int                    items_sent = 0;
    int                    rx_mode = 0;
    int                    rx_span = 0;
    int                    quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    i2c_register_access_master i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2cra_bus_checker i_bus_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_span <= $urandom_range(8, 200);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_span % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("i2c_register_access_master test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(t_cmd cmd, logic [6:0] dev, logic [7:0] regad, logic [7:0] wdata,
                             logic sda);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 48);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {sda, wdata, regad, dev};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic idle_ticks(int n);
        repeat (n) begin
            send_tick(($urandom_range(0, 1) != 0) ? CMD_SPARE : CMD_TICK, 7'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // Acts as the target device: acknowledge slots are counted in bit slots from the
    // start condition, and the device answers with a NACK at the planned slot only.
    task automatic run_transfer(t_cmd kind, logic [6:0] dev, logic [7:0] regad,
                                logic [7:0] wdata, t_nack nack_at);
        int seg_len;
        int n_seg;
        int ack_seg[3];
        logic sda;
        ack_seg[0] = 9;
        ack_seg[1] = 18;
        ack_seg[2] = (kind == CMD_READ) ? 28 : 27;
        seg_len = 4 * ((phase_len == 0) ? 1 : phase_len);
        if (nack_at == NACK_NONE) begin
            n_seg = (kind == CMD_READ) ? 39 : 29;
        end else begin
            n_seg = ack_seg[int'(nack_at) - 1] + 2;
        end
        for (int k = 0; k < n_seg * seg_len; k++) begin
            sda = 1'($urandom_range(0, 1));
            for (int b = 0; b < 3; b++) begin
                if (k / seg_len == ack_seg[b]) begin
                    sda = (b + 1 == int'(nack_at));
                end
            end
            if (k == 0) begin
                send_tick(kind, dev, regad, wdata, sda);
            end else begin
                send_tick(($urandom_range(0, 15) == 0) ? t_cmd'($urandom_range(0, 3)) : CMD_TICK,
                          7'($urandom), 8'($urandom), 8'($urandom), sda);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_phase_len(int value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= PHASE_W'(value);
        phase_len = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int budget;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_ticks(3);
        run_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'hFF, NACK_REG);
        idle_ticks(2);
        set_phase_len(1);
        run_transfer(CMD_WRITE, 7'h00, 8'h00, 8'h00, NACK_NONE);
        run_transfer(CMD_READ, 7'h7F, 8'h00, 8'h00, NACK_NONE);
        run_transfer(CMD_READ, 7'h2A, 8'hFF, 8'h55, NACK_THIRD);
        run_transfer(CMD_WRITE, 7'h01, 8'h80, 8'h01, NACK_THIRD);
        set_phase_len(0);
        run_transfer(CMD_READ, 7'h40, 8'h01, 8'h80, NACK_ADDR_WR);

        // A transfer begun with the longest phase is finished after a switch to the shortest.
        set_phase_len(PHASE_MAX);
        send_tick(CMD_WRITE, 7'h12, 8'h34, 8'h56, 1'b0);
        idle_ticks(20);
        set_phase_len(1);
        idle_ticks(130);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_phase_len(1);
                1: set_phase_len(0);
                default: set_phase_len($urandom_range(1, 2));
            endcase
            budget = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < budget) begin
                idle_ticks($urandom_range(0, 3));
                run_transfer(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE,
                             7'($urandom), 8'($urandom), 8'($urandom),
                             ($urandom_range(0, 3) == 0) ? t_nack'($urandom_range(1, 3))
                                                         : NACK_NONE);
                if ($urandom_range(0, 5) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("i2c_register_access_master test passed");
        end else begin
            $display("i2c_register_access_master test failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/i2cra_pkg.sv
design/i2cra_core.sv
design/i2c_register_access_master.sv
verif/i2cra_tb_pkg.sv
verif/i2cra_bus_checker.sv
verif/tb_top.sv
